/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while rst_n is low.
`define LQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define LQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lqs_pkg.sv */
// Types, constants and helpers for the link quality statistics block.
package lqs_pkg;

  localparam int TRACKER_COUNT = 32;
  localparam int IDX_W = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;

  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_REPORT = 1'b1
  } lqs_mode_t;

  localparam logic [7:0] KIND_ROT_A = 8'd1;
  localparam logic [7:0] KIND_ROT_B = 8'd2;
  localparam logic [7:0] KIND_ROT_C = 8'd4;
  localparam logic [7:0] KIND_ROT_D = 8'd6;
  localparam logic [7:0] KIND_ROT_E = 8'd7;
  localparam logic [7:0] LONG_GAP_LIMIT = 8'd3;

  typedef struct packed {
    logic       mode;
    logic [4:0] tracker_index;
    logic [7:0] sequence_number;
    logic [7:0] packet_kind;
    logic       in_own_window;
  } lqs_in_t;

  typedef struct packed {
    logic [7:0] received_count;
    logic [7:0] lost_count;
    logic [7:0] window_hits;
    logic [7:0] window_misses;
    logic [7:0] repeat_count;
    logic [7:0] largest_gap;
    logic [7:0] largest_rotation_gap;
    logic       long_gap_seen;
  } lqs_out_t;

  // One tracker's statistics entry.
  typedef struct packed {
    logic [7:0] received;
    logic [7:0] lost;
    logic [7:0] hits;
    logic [7:0] misses;
    logic [7:0] repeats;
    logic [7:0] gap_max;
    logic [7:0] rot_gap_max;
    logic [7:0] last_seq;
    logic [7:0] last_rot;
  } lqs_entry_t;

  function automatic logic is_rotation(input logic [7:0] kind);
    return (kind == KIND_ROT_A) || (kind == KIND_ROT_B) || (kind == KIND_ROT_C) ||
           (kind == KIND_ROT_D) || (kind == KIND_ROT_E);
  endfunction

endpackage

/* src/lqs_update.sv */
// Per-request entry update: record or report, plus the result item.
module lqs_update (
  input  lqs_pkg::lqs_in_t    req,
  input  lqs_pkg::lqs_entry_t entry,
  output lqs_pkg::lqs_entry_t entry_nxt,
  output lqs_pkg::lqs_out_t   result
);
  import lqs_pkg::*;

  logic [7:0] seq_dist;
  logic [7:0] gap;
  logic [7:0] rdist;
  logic [7:0] rgap;
  logic       is_new;
  logic       long_gap;

  assign seq_dist = req.sequence_number - entry.last_seq;
  assign gap      = seq_dist - 8'd1;
  assign rdist    = req.sequence_number - entry.last_rot;
  assign rgap     = rdist - 8'd1;
  assign is_new   = (req.sequence_number != entry.last_seq);
  assign long_gap = is_new && (seq_dist > LONG_GAP_LIMIT);

  always_comb begin
    entry_nxt = entry;
    if (req.mode == MODE_REPORT) begin
      entry_nxt.received    = '0;
      entry_nxt.lost        = '0;
      entry_nxt.hits        = '0;
      entry_nxt.misses      = '0;
      entry_nxt.repeats     = '0;
      entry_nxt.gap_max     = '0;
      entry_nxt.rot_gap_max = '0;
    end else if (is_new) begin
      entry_nxt.received = entry.received + 8'd1;
      entry_nxt.lost     = entry.lost + gap;
      entry_nxt.last_seq = req.sequence_number;
      if (req.in_own_window) begin
        entry_nxt.hits = entry.hits + 8'd1;
      end else begin
        entry_nxt.misses = entry.misses + 8'd1;
      end
      if (gap > entry.gap_max) begin
        entry_nxt.gap_max = gap;
      end
      if (is_rotation(req.packet_kind)) begin
        // zero rotation distance only moves the last rotation number
        if ((rdist != 8'd0) && (rgap > entry.rot_gap_max)) begin
          entry_nxt.rot_gap_max = rgap;
        end
        entry_nxt.last_rot = req.sequence_number;
      end
    end else begin
      entry_nxt.repeats = entry.repeats + 8'd1;
    end
  end

  // report returns the counters before clearing, record the ones after update
  always_comb begin
    if (req.mode == MODE_REPORT) begin
      result.received_count       = entry.received;
      result.lost_count           = entry.lost;
      result.window_hits          = entry.hits;
      result.window_misses        = entry.misses;
      result.repeat_count         = entry.repeats;
      result.largest_gap          = entry.gap_max;
      result.largest_rotation_gap = entry.rot_gap_max;
      result.long_gap_seen        = 1'b0;
    end else begin
      result.received_count       = entry_nxt.received;
      result.lost_count           = entry_nxt.lost;
      result.window_hits          = entry_nxt.hits;
      result.window_misses        = entry_nxt.misses;
      result.repeat_count         = entry_nxt.repeats;
      result.largest_gap          = entry_nxt.gap_max;
      result.largest_rotation_gap = entry_nxt.rot_gap_max;
      result.long_gap_seen        = long_gap;
    end
  end

endmodule

/* src/link_quality_statistics.sv */
// Top level of the link quality statistics block: request and result stages, entry table.
//
// Usage:
//   in_valid/in_stall/in_data carry requests. mode 0 records one received
//   packet for tracker_index; mode 1 reports that tracker's counters and
//   clears them (the last sequence and rotation numbers are kept).
//   out_valid/out_stall/out_data carry exactly one result per request,
//   in request order.
// Path: an accepted request is held in the request register, then its result
//   in the result register, which drives out_data.
// Throughput: one request per cycle unless out_stall holds the result. The entry
//   is read and updated between the request and result registers and written
//   back as the request moves on, so requests to the same tracker follow with no bubble.
// Reset: rst_n low clears all 32 entries and both valid flags; requests are
//   taken as soon as rst_n is released.
// Receiver stall: out_stall holds the result register. The request register
//   still fills while the result waits; once both are full, in_stall rises
//   and stays until the result is taken.
// An index outside the table returns an all-zero result and changes nothing.
module link_quality_statistics (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lqs_pkg::lqs_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lqs_pkg::lqs_out_t out_data
);
  import lqs_pkg::*;

`include "assert_macros.svh"

  // request stage
  logic       req_valid_r;
  lqs_in_t    req_r;

  // result stage
  logic       res_valid_r;
  lqs_out_t   res_r;

  // statistics table, one entry per tracker
  lqs_entry_t table_r [TRACKER_COUNT];

  logic       advance;
  logic       fire;
  logic       idx_ok;
  logic [IDX_W-1:0] idx;
  lqs_entry_t entry_cur;
  lqs_entry_t entry_nxt;
  lqs_out_t   upd_result;
  lqs_out_t   res_nxt;

  // result register can take a new item when empty or being drained
  assign advance  = !res_valid_r || !out_stall;
  assign fire     = req_valid_r && advance;
  assign in_stall = req_valid_r && !advance;

  assign idx       = req_r.tracker_index[IDX_W-1:0];
  assign idx_ok    = ({1'b0, req_r.tracker_index} < 6'(TRACKER_COUNT));
  assign entry_cur = table_r[idx];

  lqs_update u_update (
    .req       (req_r),
    .entry     (entry_cur),
    .entry_nxt (entry_nxt),
    .result    (upd_result)
  );

  assign res_nxt = idx_ok ? upd_result : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // entry write-back; the next request sees the updated entry at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACKER_COUNT; i++) begin
        table_r[i] <= '0;
      end
    end else if (fire && idx_ok) begin
      table_r[idx] <= entry_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // a request that leaves the request stage lands in the result stage
  `LQS_ASSERT(a_fire_to_result, fire |=> res_valid_r, "request lost between stages")
  // the request side only stalls while a result is held back
  `LQS_ASSERT_ALWAYS(a_stall_needs_result, in_stall |-> (res_valid_r && out_stall), "spurious in_stall")
  // a long gap forces the largest gap to at least the gap limit
  `LQS_ASSERT(a_long_gap_max, (res_valid_r && res_r.long_gap_seen) |-> (res_r.largest_gap >= LONG_GAP_LIMIT), "long gap not reflected in largest gap")

endmodule

/* bench/link_quality_statistics_test.sv */
// Self-checking testbench for link_quality_statistics: directed, wrap, random and backpressure runs.
module link_quality_statistics_test;
  import lqs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int MAX_REPORTED = 40;
  localparam logic [7:0] ROTATION_KINDS [5] =
    '{KIND_ROT_A, KIND_ROT_B, KIND_ROT_C, KIND_ROT_D, KIND_ROT_E};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lqs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lqs_out_t out_data;

  // Expected per-tracker statistics, updated at each accepted request.
  lqs_entry_t tracker_stats [TRACKER_COUNT];
  // Expected results, oldest first.
  lqs_out_t   expected_stats [$];

  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int input_stall_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // Long receiver hold-off: bumped by the stimulus, served by the receiver process.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_quality_statistics DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Predicts one request's result and advances the tracker's statistics.
  function automatic lqs_out_t predict_stats(input lqs_in_t req);
    lqs_out_t   res;
    lqs_entry_t prior;
    lqs_entry_t after;
    lqs_entry_t shown;
    logic [7:0] seq_dist;
    logic [7:0] gap;
    logic [7:0] rdist;
    logic       rotation;
    logic       long_gap;
    res = '0;
    if (req.tracker_index >= TRACKER_COUNT) return res;
    prior = tracker_stats[req.tracker_index];
    after = prior;
    long_gap = 1'b0;
    if (req.mode == MODE_REPORT) begin
      // Counters come back as they were, then clear; last numbers survive.
      shown = prior;
      after.received = '0;
      after.lost = '0;
      after.hits = '0;
      after.misses = '0;
      after.repeats = '0;
      after.gap_max = '0;
      after.rot_gap_max = '0;
    end else begin
      if (req.sequence_number != prior.last_seq) begin
        seq_dist = req.sequence_number - prior.last_seq;
        gap = seq_dist - 8'd1;
        after.received = prior.received + 8'd1;
        if (req.in_own_window) after.hits = prior.hits + 8'd1;
        else after.misses = prior.misses + 8'd1;
        after.lost = prior.lost + gap;
        after.last_seq = req.sequence_number;
        if (gap > prior.gap_max) after.gap_max = gap;
        rotation = 1'b0;
        foreach (ROTATION_KINDS[i])
          if (req.packet_kind == ROTATION_KINDS[i]) rotation = 1'b1;
        if (rotation) begin
          // Zero rotation distance leaves the max alone but still moves last_rot.
          rdist = req.sequence_number - prior.last_rot;
          if (rdist != 8'd0 && (rdist - 8'd1) > prior.rot_gap_max)
            after.rot_gap_max = rdist - 8'd1;
          after.last_rot = req.sequence_number;
        end
        long_gap = (seq_dist > LONG_GAP_LIMIT);
      end else begin
        after.repeats = prior.repeats + 8'd1;
      end
      shown = after;
    end
    tracker_stats[req.tracker_index] = after;
    res.received_count = shown.received;
    res.lost_count = shown.lost;
    res.window_hits = shown.hits;
    res.window_misses = shown.misses;
    res.repeat_count = shown.repeats;
    res.largest_gap = shown.gap_max;
    res.largest_rotation_gap = shown.rot_gap_max;
    res.long_gap_seen = long_gap;
    return res;
  endfunction

  function automatic lqs_in_t make_req(input lqs_mode_t mode, input int idx, input int seq,
                                       input int kind, input int own);
    lqs_in_t r;
    r.mode = mode;
    r.tracker_index = idx[4:0];
    r.sequence_number = seq[7:0];
    r.packet_kind = kind[7:0];
    r.in_own_window = own[0];
    return r;
  endfunction

  function automatic int random_kind();
    if ($urandom_range(1) == 0) return int'(ROTATION_KINDS[$urandom_range(4)]);
    return $urandom_range(255);
  endfunction

  // Mostly well-formed packet streams to a few focus trackers, some noise and reports.
  function automatic lqs_in_t random_request(input int focus_base);
    int pick;
    int idx;
    int step;
    pick = $urandom_range(99);
    if (pick < 12)
      return make_req(($urandom_range(1) == 0) ? MODE_REPORT : MODE_RECORD,
                      $urandom_range(TRACKER_COUNT - 1), $urandom_range(255),
                      $urandom_range(255), $urandom_range(1));
    idx = (focus_base + $urandom_range(3)) % TRACKER_COUNT;
    if (pick < 15)
      return make_req(MODE_REPORT, idx, $urandom_range(255), $urandom_range(255),
                      $urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 65) step = 1;
    else if (pick < 80) step = 0;
    else if (pick < 95) step = $urandom_range(2, 6);
    else step = $urandom_range(255);
    return make_req(MODE_RECORD, idx, tracker_stats[idx].last_seq + step, random_kind(),
                    $urandom_range(1));
  endfunction

  task automatic set_idling(input int send_pct, input int stall_pct);
    sender_idle_pct = send_pct;
    receiver_stall_pct <= stall_pct;
  endtask

  // Offers one request, idling first at random; returns at the accepting edge.
  task automatic send_request(input lqs_in_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    expected_stats.push_back(predict_stats(req));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Result checker: every taken result against the oldest expectation.
  always @(posedge clk) begin : check_results
    lqs_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_stats.pop_front();
        results_checked++;
        check_field("received_count", want.received_count, out_data.received_count);
        check_field("lost_count", want.lost_count, out_data.lost_count);
        check_field("window_hits", want.window_hits, out_data.window_hits);
        check_field("window_misses", want.window_misses, out_data.window_misses);
        check_field("repeat_count", want.repeat_count, out_data.repeat_count);
        check_field("largest_gap", want.largest_gap, out_data.largest_gap);
        check_field("largest_rotation_gap", want.largest_rotation_gap,
                    out_data.largest_rotation_gap);
        check_field("long_gap_seen", {7'd0, want.long_gap_seen}, {7'd0, out_data.long_gap_seen});
      end
    end
  end

  // Repeat from reset, distances 1, 3, 4 and 255, max kind.
  task automatic test_sequence_gaps();
    set_idling(0, 0);
    send_request(make_req(MODE_RECORD, 0, 0, 0, 0));
    send_request(make_req(MODE_RECORD, 0, 1, KIND_ROT_A, 1));
    send_request(make_req(MODE_RECORD, 0, 4, 0, 0));
    send_request(make_req(MODE_RECORD, 0, 8, KIND_ROT_B, 1));
    send_request(make_req(MODE_RECORD, 0, 7, 0, 0));
    send_request(make_req(MODE_RECORD, 0, 7, 0, 1));
    send_request(make_req(MODE_RECORD, 0, 255, 255, 1));
  endtask

  // Rotation kinds, non-rotation neighbors, rotation distance zero.
  task automatic test_rotation_gaps();
    send_request(make_req(MODE_RECORD, 1, 10, KIND_ROT_C, 1));
    send_request(make_req(MODE_RECORD, 1, 11, 3, 0));
    send_request(make_req(MODE_RECORD, 1, 10, KIND_ROT_D, 1));
    send_request(make_req(MODE_RECORD, 1, 200, KIND_ROT_E, 0));
    send_request(make_req(MODE_RECORD, 1, 201, 8, 1));
    send_request(make_req(MODE_RECORD, 1, 9, KIND_ROT_A, 0));
  endtask

  // Report then clear; last numbers must survive the clear. Top index too.
  task automatic test_reports();
    send_request(make_req(MODE_REPORT, 0, 0, 0, 1));
    send_request(make_req(MODE_REPORT, 0, 0, 0, 0));
    send_request(make_req(MODE_RECORD, 0, 8, KIND_ROT_A, 1));
    send_request(make_req(MODE_REPORT, 1, 0, 0, 0));
    send_request(make_req(MODE_RECORD, TRACKER_COUNT - 1, 128, KIND_ROT_B, 1));
    send_request(make_req(MODE_REPORT, TRACKER_COUNT - 1, 255, 255, 1));
    send_request(make_req(MODE_RECORD, TRACKER_COUNT - 1, 128, 0, 0));
    send_request(make_req(MODE_REPORT, TRACKER_COUNT - 1, 0, 0, 0));
    wait_all_results();
  endtask

  // New packet plus repeat, 270 times on one tracker: received, hits,
  // repeats and lost all pass 255.
  task automatic test_counter_wrap();
    lqs_in_t pkt;
    int      idx;
    idx = $urandom_range(TRACKER_COUNT - 1);
    set_idling(7, 7);
    for (int n = 0; n < 270; n++) begin
      pkt = make_req(MODE_RECORD, idx, tracker_stats[idx].last_seq + $urandom_range(1, 3),
                     random_kind(), int'($urandom_range(49) != 0));
      send_request(pkt);
      pkt.packet_kind = 8'($urandom_range(255));
      pkt.in_own_window = 1'($urandom_range(1));
      send_request(pkt);
    end
    send_request(make_req(MODE_REPORT, idx, 0, 0, 0));
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count);
    int base;
    base = $urandom_range(TRACKER_COUNT - 1);
    set_idling(send_pct, stall_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 19) base = $urandom_range(TRACKER_COUNT - 1);
      send_request(random_request(base));
    end
  endtask

  // Receiver holds off while requests keep coming, so in_stall must rise;
  // then the sender waits for every result.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 24; n++)
      send_request(random_request(n % TRACKER_COUNT));
    wait_all_results();
  endtask

  initial begin
    foreach (tracker_stats[i]) tracker_stats[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_sequence_gaps();
    test_rotation_gaps();
    test_reports();
    test_counter_wrap();
    test_random_traffic(0, 0, 70);
    test_random_traffic(53, 0, 70);
    test_random_traffic(0, 53, 70);
    test_random_traffic(7, 7, 70);
    test_backpressure();
    // One request register and one result register: waiting past them catches strays.
    repeat (4) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d cycles with input stalled",
             requests_sent, results_checked, input_stall_cycles);
    $display("covered gaps, repeats, rotation gaps, reports, counter wrap, idling, backpressure");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_stats.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* link_quality_statistics.f */
+incdir+src
src/lqs_pkg.sv
src/lqs_update.sv
src/link_quality_statistics.sv
bench/link_quality_statistics_test.sv
